FILE: rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam int CW = 34;
  localparam int GW = 24;
  localparam int PW = 48;
  localparam int TW = 42;
  localparam int MAGW = 43;
  localparam int DIVN = 63;
  localparam int DIVD = 32;
  localparam int DIV_CNT_W = $clog2(DIVN + 1);

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;
  localparam logic [19:0] USEC_PER_S = 20'd1000000;
  localparam logic signed [PW-1:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [PW-1:0] SAT_MIN = 48'sh8000_0000_0000;
  localparam logic [GW-1:0] THETA_GAIN_RST = 24'd143646;
  localparam logic [GW-1:0] DIST_GAIN_RST = 24'd155689;

  typedef enum logic [1:0] {
    REG_THETA_GAIN = 2'd0,
    REG_DIST_GAIN  = 2'd1
  } reg_idx_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [PW-1:0] sat48(input logic signed [PW:0] v);
    logic signed [PW-1:0] r;
    if (v[PW] != v[PW-1]) begin
      r = v[PW] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/ddo_if.sv
interface ddo_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_ticks;
  logic signed [15:0] right_ticks;
  logic [31:0] time_us;
  modport source(output valid, left_ticks, right_ticks, time_us, input ready);
  modport sink(input valid, left_ticks, right_ticks, time_us, output ready);
endinterface

interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic [31:0] heading;
  logic signed [47:0] vel_x;
  logic signed [47:0] vel_y;
  logic signed [47:0] turn_rate;
  logic rate_valid;
  modport source(output valid, pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
                 rate_valid, input ready);
  modport sink(input valid, pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
               rate_valid, output ready);
endinterface

FILE: rtl/ddo_cordic.sv
module ddo_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] angle,
  output logic done,
  output logic signed [ddo_pkg::CW-1:0] cos_out,
  output logic signed [ddo_pkg::CW-1:0] sin_out
);

  logic running;
  logic [ddo_pkg::CNT_W-1:0] cnt;
  logic signed [ddo_pkg::CW-1:0] x;
  logic signed [ddo_pkg::CW-1:0] y;
  logic signed [ddo_pkg::CW-1:0] z;
  logic [1:0] quad;

  logic [31:0] qa;
  logic [31:0] resid;
  logic signed [ddo_pkg::CW-1:0] xs;
  logic signed [ddo_pkg::CW-1:0] ys;
  logic signed [ddo_pkg::CW-1:0] at;

  always_comb begin
    qa = angle + 32'h2000_0000;
    resid = angle - {qa[31:30], 30'b0};
    xs = x >>> cnt[4:0];
    ys = y >>> cnt[4:0];
    at = ddo_pkg::CW'({2'b00, ddo_pkg::atan_entry(cnt[4:0])});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= ddo_pkg::CORDIC_X0;
        y <= '0;
        z <= ddo_pkg::CW'($signed(resid));
        quad <= qa[31:30];
        cnt <= '0;
        running <= 1'b1;
      end else if (running) begin
        if (cnt == ddo_pkg::CNT_W'(ddo_pkg::CORDIC_STEPS)) begin
          running <= 1'b0;
          done <= 1'b1;
          case (quad)
            2'd0: begin
              cos_out <= x;
              sin_out <= y;
            end
            2'd1: begin
              cos_out <= -y;
              sin_out <= x;
            end
            2'd2: begin
              cos_out <= -x;
              sin_out <= -y;
            end
            default: begin
              cos_out <= y;
              sin_out <= -x;
            end
          endcase
        end else begin
          if (!z[ddo_pkg::CW-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/ddo_div.sv
module ddo_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ddo_pkg::DIVN-1:0] dividend,
  input  logic [ddo_pkg::DIVD-1:0] divisor,
  output logic done,
  output logic [ddo_pkg::DIVN-1:0] quotient
);

  logic running;
  logic [ddo_pkg::DIV_CNT_W-1:0] cnt;
  logic [ddo_pkg::DIVD-1:0] rem;
  logic [ddo_pkg::DIVD:0] trial;
  logic fits;

  always_comb begin
    trial = {rem, quotient[ddo_pkg::DIVN-1]};
    fits = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quotient <= dividend;
        cnt <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= fits ? ddo_pkg::DIVD'(trial - {1'b0, divisor})
                    : trial[ddo_pkg::DIVD-1:0];
        quotient <= {quotient[ddo_pkg::DIVN-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIVN - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/diff_drive_odometry.sv
// channel  dir  payload                                          transfer
// din      in   left_ticks, right_ticks, time_us                 valid & ready
// dout     out  pos_x, pos_y, heading, vel_x, vel_y, turn_rate,  valid & ready
//               rate_valid
// cfg      in   cfg_we, cfg_index, cfg_data                      cfg_we
// an item without velocities passes the transfer, the cordic (load, 24 rotations, output,
// handoff), the shared multiply and the dout load; with velocities add three passes of the
// bit-serial divider (dividend load, start, 63 steps, handoff) between multiply and dout load
// din is ready only while the sequencer is idle; a result held in dout does not
// block the next transfer, only the final load of the following result
// rst is synchronous and restores the gains, clears pose, timestamp and dout.valid
module diff_drive_odometry (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [ddo_pkg::GW-1:0] cfg_data,
  ddo_in_if.sink din,
  ddo_out_if.source dout
);

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_MUL, S_DLOAD, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic [ddo_pkg::GW-1:0] theta_gain;
  logic [ddo_pkg::GW-1:0] distance_gain;
  logic signed [ddo_pkg::PW-1:0] x_accum;
  logic signed [ddo_pkg::PW-1:0] y_accum;
  logic [31:0] heading_accum;
  logic [31:0] last_time;
  logic have_last;

  logic signed [ddo_pkg::TW-1:0] dth;
  logic signed [ddo_pkg::TW-1:0] travel;
  logic [31:0] dt;
  logic rate_ok;
  logic [2:0] mstep;
  logic [73:0] acc;
  logic signed [ddo_pkg::MAGW-1:0] dx;
  logic signed [ddo_pkg::MAGW-1:0] dy;
  logic [1:0] dsel;
  logic [ddo_pkg::DIVN-1:0] dividend;
  logic div_neg;
  logic signed [ddo_pkg::PW-1:0] vx;
  logic signed [ddo_pkg::PW-1:0] vy;
  logic signed [ddo_pkg::PW-1:0] wz;
  logic cord_start;
  logic div_start;

  logic cord_done;
  logic signed [ddo_pkg::CW-1:0] cos_v;
  logic signed [ddo_pkg::CW-1:0] sin_v;
  logic div_done;
  logic [ddo_pkg::DIVN-1:0] quo;

  logic signed [16:0] tick_diff;
  logic signed [16:0] tick_sum;
  logic signed [ddo_pkg::TW-1:0] dth_calc;
  logic signed [ddo_pkg::TW-1:0] dist_calc;
  logic [40:0] dist_mag;
  logic signed [ddo_pkg::CW-1:0] trig;
  logic [32:0] trig_mag;
  logic [20:0] mul_part;
  logic [53:0] prod;
  logic [43:0] rounded;
  logic signed [ddo_pkg::MAGW-1:0] dq_signed;
  logic prod_neg;
  logic signed [ddo_pkg::MAGW-1:0] dsrc;
  logic [ddo_pkg::MAGW-1:0] dsrc_mag;
  logic signed [ddo_pkg::PW-1:0] vel_sat;
  logic in_xfer;

  assign in_xfer = din.valid && din.ready;
  assign din.ready = (state == S_IDLE);

  always_comb begin
    tick_diff = 17'(din.right_ticks) - 17'(din.left_ticks);
    tick_sum = 17'(din.right_ticks) + 17'(din.left_ticks);
    dth_calc = $signed({1'b0, theta_gain}) * tick_diff;
    dist_calc = $signed({1'b0, distance_gain}) * tick_sum;
    dist_mag = travel[ddo_pkg::TW-1] ? 41'(-travel) : 41'(travel);
    trig = (mstep < 3'd2) ? cos_v : sin_v;
    trig_mag = trig[ddo_pkg::CW-1] ? 33'(-trig) : 33'(trig);
    mul_part = mstep[0] ? {1'b0, dist_mag[40:21]} : dist_mag[20:0];
    prod = 54'(mul_part) * 54'(trig_mag);
    rounded = 44'((acc + 74'h2000_0000) >> 30);
    // dx is rounded at step 2 while the sine product is already being formed
    prod_neg = travel[ddo_pkg::TW-1] ^
               ((mstep == 3'd2) ? cos_v[ddo_pkg::CW-1] : sin_v[ddo_pkg::CW-1]);
    dq_signed = prod_neg ? -$signed(rounded[42:0]) : $signed(rounded[42:0]);
    case (dsel)
      2'd0: dsrc = dx;
      2'd1: dsrc = dy;
      default: dsrc = ddo_pkg::MAGW'(dth);
    endcase
    dsrc_mag = dsrc[ddo_pkg::MAGW-1] ? ddo_pkg::MAGW'(-dsrc) : ddo_pkg::MAGW'(dsrc);
    if (quo[ddo_pkg::DIVN-1:ddo_pkg::PW-1] != '0) begin
      vel_sat = div_neg ? ddo_pkg::SAT_MIN : ddo_pkg::SAT_MAX;
    end else if (div_neg) begin
      vel_sat = -$signed(quo[ddo_pkg::PW-1:0]);
    end else begin
      vel_sat = $signed(quo[ddo_pkg::PW-1:0]);
    end
  end

  ddo_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cord_start),
    .angle(heading_accum),
    .done(cord_done),
    .cos_out(cos_v),
    .sin_out(sin_v)
  );

  ddo_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(dividend),
    .divisor(dt),
    .done(div_done),
    .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      theta_gain <= ddo_pkg::THETA_GAIN_RST;
      distance_gain <= ddo_pkg::DIST_GAIN_RST;
      x_accum <= '0;
      y_accum <= '0;
      heading_accum <= '0;
      last_time <= '0;
      have_last <= 1'b0;
      cord_start <= 1'b0;
      div_start <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      cord_start <= 1'b0;
      div_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_THETA_GAIN: theta_gain <= cfg_data;
          ddo_pkg::REG_DIST_GAIN: distance_gain <= cfg_data;
          default: ;
        endcase
      end
      if (dout.valid && dout.ready && state != S_FIN) begin
        dout.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            dth <= dth_calc;
            travel <= dist_calc;
            dt <= din.time_us - last_time;
            rate_ok <= have_last && (din.time_us != last_time);
            last_time <= din.time_us;
            have_last <= 1'b1;
            vx <= '0;
            vy <= '0;
            wz <= '0;
            cord_start <= 1'b1;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cord_done) begin
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 1'b1;
          case (mstep)
            3'd0: acc <= 74'(prod);
            3'd1: acc <= acc + (74'(prod) << 21);
            3'd2: begin
              dx <= dq_signed;
              acc <= 74'(prod);
            end
            3'd3: acc <= acc + (74'(prod) << 21);
            3'd4: dy <= dq_signed;
            default: begin
              x_accum <= ddo_pkg::sat48((ddo_pkg::PW + 1)'(x_accum) +
                                        (ddo_pkg::PW + 1)'(dx));
              y_accum <= ddo_pkg::sat48((ddo_pkg::PW + 1)'(y_accum) +
                                        (ddo_pkg::PW + 1)'(dy));
              heading_accum <= heading_accum + dth[31:0];
              dsel <= '0;
              state <= rate_ok ? S_DLOAD : S_FIN;
            end
          endcase
        end
        S_DLOAD: begin
          dividend <= ddo_pkg::DIVN'(dsrc_mag) * ddo_pkg::DIVN'(ddo_pkg::USEC_PER_S);
          div_neg <= dsrc[ddo_pkg::MAGW-1];
          div_start <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            case (dsel)
              2'd0: vx <= vel_sat;
              2'd1: vy <= vel_sat;
              default: wz <= vel_sat;
            endcase
            dsel <= dsel + 1'b1;
            state <= (dsel == 2'd2) ? S_FIN : S_DLOAD;
          end
        end
        S_FIN: begin
          if (!dout.valid || dout.ready) begin
            dout.valid <= 1'b1;
            dout.pos_x <= x_accum;
            dout.pos_y <= y_accum;
            dout.heading <= heading_accum;
            dout.vel_x <= vx;
            dout.vel_y <= vy;
            dout.turn_rate <= wz;
            dout.rate_valid <= rate_ok;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> state == S_CORDIC) else $error("cordic finished outside its wait");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider finished outside its wait");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !din.ready) else $error("input ready right after a transfer");

  a_no_rate_zero: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.rate_valid) |->
      (dout.vel_x == '0 && dout.vel_y == '0 && dout.turn_rate == '0))
    else $error("velocity reported without rate");

endmodule
